// ----- hdl/sha_pkg.sv -----
package sha_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_vars_t;

  typedef enum logic [2:0] {
    PAD_MARK = 3'b001,
    PAD_ZERO = 3'b010,
    PAD_LEN  = 3'b100
  } pad_phase_t;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam int unsigned LEN_POS   = 56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/sha256_byte_stream_hasher.sv -----
// SHA-256 over a byte stream. One byte is taken per transfer on s_axis; a
// transfer with tlast ends the message, and tuser low marks a transfer with no
// byte (use it alone with tlast to hash an empty message). Every 64th byte
// starts a block compression (loading the block memory into the schedule
// window, 64 rounds at one per cycle, then read-add-write into the chain hash
// memory), during which s_tready is low. On the end of message the padding
// bytes are generated internally at one per cycle while no compression runs,
// with an idle step before the length field, followed by one or two
// compressions, and then the eight digest words leave on m_axis, H0 first;
// each word is read from the chain memory only after the previous word has
// been accepted. The block then starts over for the next message.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // msg_byte
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
  output logic        m_tlast    // last_word
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PAD   = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_ROUND = 8'b0000_1000,
    ST_FINAL = 8'b0001_0000,
    ST_ERD   = 8'b0010_0000,
    ST_ELD   = 8'b0100_0000,
    ST_EHOLD = 8'b1000_0000
  } state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic [5:0]  pos;
  logic [63:0] bit_count;
  logic [23:0] acc;
  logic        pad_active;
  logic        final_blk;
  pad_phase_t  pad_phase;

  logic [31:0] block_mem [16];
  logic [31:0] chain_mem [8];
  logic [31:0] blk_rdata;
  logic [31:0] ch_rdata;
  logic [2:0]  ch_ridx;
  logic [7:0]  ch_valid;
  logic [31:0] ch_eff;

  logic [31:0] win [16];
  work_vars_t  vars;
  work_vars_t  vars_next;
  logic [31:0] w_new;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        s_xfer;
  logic [5:0]  pos_inc;
  logic [2:0]  emit_idx;
  logic [31:0] out_word;

  logic        blk_re;
  logic [3:0]  blk_raddr;
  logic        ch_re;
  logic [2:0]  ch_raddr;
  logic        ch_we;
  logic [2:0]  ch_waddr;
  logic [31:0] ch_wdata;

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign pos_inc  = pos + 6'd1;
  assign ch_eff   = ch_valid[ch_ridx] ? ch_rdata : init_hash(ch_ridx);
  assign m_tdata  = {5'd0, emit_idx, out_word};
  assign m_tlast  = (emit_idx == 3'd7);

  sha_round u_round (
    .vars      (vars),
    .k         (round_const(cnt)),
    .w0        (win[0]),
    .w1        (win[1]),
    .w9        (win[9]),
    .w14       (win[14]),
    .vars_next (vars_next),
    .w_new     (w_new)
  );

  // byte source: input transfer or padding generator
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = s_tdata;
    if (state == ST_IDLE) begin
      wr_en = s_xfer && s_tuser;
    end else if (state == ST_PAD) begin
      case (pad_phase)
        PAD_MARK: begin
          wr_en   = 1'b1;
          wr_byte = PAD_MARKER;
        end
        PAD_ZERO: begin
          wr_en   = (pos != 6'(LEN_POS));
          wr_byte = 8'd0;
        end
        default: begin
          wr_en   = 1'b1;
          wr_byte = 8'(bit_count >> {~pos[2:0], 3'b000});
        end
      endcase
    end
  end

  always_comb begin
    blk_re    = (state == ST_LOAD) && (cnt < 6'd16);
    blk_raddr = cnt[3:0];
    ch_re     = 1'b0;
    ch_raddr  = cnt[2:0];
    ch_we     = 1'b0;
    ch_waddr  = cnt[2:0] - 3'd1;
    ch_wdata  = ch_eff + vars.a;
    unique case (state)
      ST_LOAD:  ch_re = (cnt < 6'd8);
      ST_FINAL: begin
        ch_re = (cnt < 6'd8);
        ch_we = (cnt != 6'd0);
      end
      ST_ERD: begin
        ch_re    = 1'b1;
        ch_raddr = emit_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en && pos[1:0] == 2'd3) begin
      block_mem[pos[5:2]] <= {acc, wr_byte};
    end
    if (blk_re) begin
      blk_rdata <= block_mem[blk_raddr];
    end
    if (ch_we) begin
      chain_mem[ch_waddr] <= ch_wdata;
    end
    if (ch_re) begin
      ch_rdata <= chain_mem[ch_raddr];
      ch_ridx  <= ch_raddr;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc <= {acc[15:0], wr_byte};
    end
    unique case (state)
      ST_LOAD: begin
        if (cnt != 6'd0) begin
          for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
          win[15] <= blk_rdata;
        end
        if (cnt != 6'd0 && cnt <= 6'd8) begin
          vars <= {vars.b, vars.c, vars.d, vars.e, vars.f, vars.g, vars.h, ch_eff};
        end
      end
      ST_ROUND: begin
        vars <= vars_next;
        for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
        win[15] <= w_new;
      end
      ST_FINAL: begin
        if (cnt != 6'd0) begin
          vars <= {vars.b, vars.c, vars.d, vars.e, vars.f, vars.g, vars.h, 32'd0};
        end
      end
      ST_ELD: out_word <= ch_eff;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      pos        <= '0;
      bit_count  <= '0;
      pad_active <= 1'b0;
      final_blk  <= 1'b0;
      pad_phase  <= PAD_MARK;
      ch_valid   <= '0;
      emit_idx   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (wr_en) begin
        pos <= pos_inc;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            if (s_tuser) begin
              bit_count <= bit_count + 64'd8;
            end
            pad_active <= s_tlast;
            pad_phase  <= PAD_MARK;
            cnt        <= '0;
            if (s_tuser && pos_inc == 6'd0) begin
              state <= ST_LOAD;
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          cnt <= '0;
          case (pad_phase)
            PAD_MARK: pad_phase <= PAD_ZERO;
            PAD_ZERO: if (pos == 6'(LEN_POS)) pad_phase <= PAD_LEN;
            default: ;
          endcase
          if (pad_phase == PAD_LEN) begin
            final_blk <= 1'b1;
          end
          if (wr_en && pos_inc == 6'd0) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (cnt == 6'd16) begin
            cnt   <= '0;
            state <= ST_ROUND;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_ROUND: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (cnt != 6'd0) begin
            ch_valid[ch_waddr] <= 1'b1;
          end
          if (cnt == 6'd8) begin
            cnt      <= '0;
            emit_idx <= '0;
            if (final_blk) begin
              state <= ST_ERD;
            end else if (pad_active) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_ERD: state <= ST_ELD;
        ST_ELD: begin
          m_tvalid <= 1'b1;
          state    <= ST_EHOLD;
        end
        ST_EHOLD: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              // message done, start over
              ch_valid   <= '0;
              pos        <= '0;
              bit_count  <= '0;
              pad_active <= 1'b0;
              final_blk  <= 1'b0;
              state      <= ST_IDLE;
            end else begin
              state <= ST_ERD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/sha_round.sv -----
module sha_round
  import sha_pkg::*;
(
  input  work_vars_t  vars,
  input  logic [31:0] k,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w9,
  input  logic [31:0] w14,
  output work_vars_t  vars_next,
  output logic [31:0] w_new
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] mj;

  always_comb begin
    ch = (vars.e & vars.f) ^ (~vars.e & vars.g);
    mj = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);
    t1 = vars.h + big_sigma1(vars.e) + ch + k + w0;
    t2 = big_sigma0(vars.a) + mj;
    vars_next.a = t1 + t2;
    vars_next.b = vars.a;
    vars_next.c = vars.b;
    vars_next.d = vars.c;
    vars_next.e = vars.d + t1;
    vars_next.f = vars.e;
    vars_next.g = vars.f;
    vars_next.h = vars.g;
    // schedule word sixteen rounds ahead
    w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);
  end

endmodule

// ----- test/sha256_byte_stream_hasher_test.sv -----
`timescale 1ns / 1ps

class digest_scoreboard;
  logic [31:0] hash_state [8];
  logic [31:0] blk [16];
  logic [5:0]  byte_pos;
  logic [63:0] msg_bits;
  logic [35:0] digest_q [$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    hash_state[0] = 32'h6a09e667; hash_state[1] = 32'hbb67ae85;
    hash_state[2] = 32'h3c6ef372; hash_state[3] = 32'ha54ff53a;
    hash_state[4] = 32'h510e527f; hash_state[5] = 32'h9b05688c;
    hash_state[6] = 32'h1f83d9ab; hash_state[7] = 32'h5be0cd19;
    byte_pos = 0;
    msg_bits = 0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void place(int pos, logic [7:0] v);
    int sh;
    sh = (3 - pos % 4) * 8;
    if (pos % 4 == 0) blk[pos / 4] = 32'(v) << 24;
    else blk[pos / 4] = blk[pos / 4] | (32'(v) << sh);
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    logic [31:0] kc [64];
    kc = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + kc[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function void note_input(logic present, logic [7:0] data, logic eom);
    int pos;
    if (present) begin
      place(byte_pos, data);
      msg_bits += 64'd8;
      byte_pos += 1;
      if (byte_pos == 0) compress();
    end
    if (!eom) return;
    pos = byte_pos;
    place(pos, 8'h80);
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin place(pos, 8'h00); pos++; end
      compress();
      pos = 0;
    end
    while (pos < 56) begin place(pos, 8'h00); pos++; end
    blk[14] = msg_bits[63:32];
    blk[15] = msg_bits[31:0];
    compress();
    for (int i = 0; i < 8; i++) digest_q.push_back({i == 7, 3'(i), hash_state[i]});
    restart();
  endfunction

  function void check_word(logic [31:0] word, logic [2:0] idx, logic lst);
    logic [35:0] exp_w;
    if (digest_q.size() == 0) begin
      $display("%0t: unexpected digest word %h idx %0d", $time, word, idx);
      errors++;
      return;
    end
    exp_w = digest_q.pop_front();
    if (exp_w[31:0] !== word) begin
      $display("%0t: digest word expected %h actual %h", $time, exp_w[31:0], word);
      errors++;
    end
    if (exp_w[34:32] !== idx) begin
      $display("%0t: word index expected %0d actual %0d", $time, exp_w[34:32], idx);
      errors++;
    end
    if (exp_w[35] !== lst) begin
      $display("%0t: last flag expected %b actual %b", $time, exp_w[35], lst);
      errors++;
    end
  endfunction
endclass

module sha256_byte_stream_hasher_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic        s_tuser = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  digest_scoreboard sb = new();
  bit calm = 0;
  bit hold_sink = 0;
  bit sent_all = 0;
  int sent_items = 0;

  sha256_byte_stream_hasher dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata[31:0], m_tdata[34:32], m_tlast);
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata, s_tlast);
  end

  // sink readiness with random stall bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_sink) m_tready <= 0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        m_tready <= 0;
        repeat (n) @(posedge clk);
        m_tready <= 1;
      end else m_tready <= 1;
    end
  end

  task automatic send_item(logic present, logic [7:0] data, logic eom);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 13);
      s_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= present;
    s_tdata  <= data;
    s_tlast  <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_message(int len, bit with_end_byte);
    for (int i = 0; i < len; i++) begin
      // ignored filler items in between
      if ($urandom_range(0, 15) == 0) send_item(0, 8'($urandom), 0);
      send_item(1, 8'($urandom), with_end_byte && i == len - 1);
    end
    if (!with_end_byte || len == 0) send_item(0, 8'($urandom), 1);
  endtask

  initial begin
    int len;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty, extreme bytes, short lengths
    send_item(0, 8'hff, 1);
    send_item(0, 8'h5a, 0);
    send_item(1, 8'h00, 0);
    send_item(1, 8'hff, 0);
    send_item(0, 8'hff, 0);
    send_item(1, 8'haa, 1);
    send_item(1, 8'h55, 1);
    send_message(3, 1);
    send_message(2, 0);
    // random messages covering the padding boundaries around 56 and 64 bytes
    hold_sink = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_sink = 0;
      end
      begin
        send_message(1, 1);
        send_message(3, 1);
      end
    join
    send_message(55, 1);
    send_message(56, 1);
    send_message(64, 0);
    while (sb.digest_q.size() > 0 || !calm) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
      send_message(len, $urandom_range(0, 1));
      if ($urandom_range(0, 30) == 0) send_item(0, 8'($urandom), 0);
      if (!calm && sb.msg_bits == 0 && sent_items >= 380) calm = 1;
      else if (calm) break;
    end
    calm = 1;
    send_message(7, 1);
    s_tvalid <= 0;
    sent_all = 1;
  end

  initial begin
    wait (sent_all);
    while (sb.digest_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.digest_q.size() == 0) $display("sha256_byte_stream_hasher_test OK");
    else $display("sha256_byte_stream_hasher_test NOT OK");
    $finish;
  end

  initial begin
    #3000000;
    $display("sha256_byte_stream_hasher_test NOT OK");
    $finish;
  end
endmodule
